>>> hw/rtl/wpt_pkg.sv
// ----------------------------------------------------------------------------
// wpt_pkg: shared definitions for the window percentile tracker
// Sizes, request codes, sequencer states and the control bundle that the
// sequencer hands to the rank unit.
// ----------------------------------------------------------------------------
package wpt_pkg;

  localparam int WINDOW   = 600;
  localparam int ADDR_W   = $clog2(WINDOW);
  localparam int CNT_W    = $clog2(WINDOW + 1);
  localparam int SAMPLE_W = 16;
  localparam int BIT_W    = $clog2(SAMPLE_W);
  localparam int DUR_W    = 32;
  localparam int PCT_IN_W = 8;
  localparam int PCT_MAX  = 100;
  localparam int PCT_W    = $clog2(PCT_MAX + 1);
  // Scaled rank: percent * (count - 1), i.e. the rank multiplied by one hundred.
  localparam int RANK_W   = $clog2(PCT_MAX * (WINDOW - 1) + 1);
  // One hundred times a match count.
  localparam int HUND_W   = $clog2(PCT_MAX * WINDOW + 1);

  typedef enum logic [1:0] {
    ACT_PUSH  = 2'd0,
    ACT_QUERY = 2'd1,
    ACT_CLEAR = 2'd2
  } action_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_SCAN,
    ST_DRAIN,
    ST_RESOLVE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;     // load scaled rank, clear prefix and match count
    logic acc;      // count the sample on the read data if it matches
    logic resolve;  // decide the current bit and clear the match count
  } rank_ctrl_t;

endpackage

>>> hw/rtl/wpt_sample_ram.sv
// ----------------------------------------------------------------------------
// wpt_sample_ram: sample ring storage
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module wpt_sample_ram (
  input  logic                          clk,
  input  logic                          we,
  input  logic [wpt_pkg::ADDR_W-1:0]    waddr,
  input  logic [wpt_pkg::SAMPLE_W-1:0]  wdata,
  input  logic                          re,
  input  logic [wpt_pkg::ADDR_W-1:0]    raddr,
  output logic [wpt_pkg::SAMPLE_W-1:0]  rdata
);

  logic [wpt_pkg::SAMPLE_W-1:0] mem [wpt_pkg::WINDOW];
  logic [wpt_pkg::SAMPLE_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hw/rtl/wpt_rank_unit.sv
// ----------------------------------------------------------------------------
// wpt_rank_unit: bitwise order-statistic selector
// Builds the selected sample one bit per pass, from the top bit down, by
// counting the samples that share the prefix and hold a zero at the bit.
// ----------------------------------------------------------------------------
module wpt_rank_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  wpt_pkg::rank_ctrl_t           ctrl,
  input  logic [wpt_pkg::RANK_W-1:0]    rank_load,
  input  logic [wpt_pkg::BIT_W-1:0]     bit_idx,
  input  logic [wpt_pkg::SAMPLE_W-1:0]  sample,
  output logic [wpt_pkg::SAMPLE_W-1:0]  prefix
);

  logic [wpt_pkg::RANK_W-1:0]   rank_r,   rank_nxt;
  logic [wpt_pkg::CNT_W-1:0]    cnt_r,    cnt_nxt;
  logic [wpt_pkg::SAMPLE_W-1:0] prefix_r, prefix_nxt;
  logic [wpt_pkg::SAMPLE_W:0]   mask_wide;
  logic [wpt_pkg::SAMPLE_W-1:0] mask_hi;
  logic [wpt_pkg::SAMPLE_W-1:0] bit_sel;
  logic                         match;
  logic [wpt_pkg::HUND_W-1:0]   hund;
  logic [wpt_pkg::HUND_W-1:0]   rank_ext;

  // Bits above the current one must equal the prefix; the current bit must be 0.
  assign mask_wide = {{wpt_pkg::SAMPLE_W{1'b1}}, 1'b0} << bit_idx;
  assign mask_hi   = mask_wide[wpt_pkg::SAMPLE_W-1:0];
  assign bit_sel   = {{(wpt_pkg::SAMPLE_W-1){1'b0}}, 1'b1} << bit_idx;
  assign match     = (((sample ^ prefix_r) & mask_hi) == '0) && ((sample & bit_sel) == '0);

  // The rank is held scaled by one hundred, so it is compared against 100 * count.
  assign hund     = wpt_pkg::HUND_W'(cnt_r) * wpt_pkg::HUND_W'(wpt_pkg::PCT_MAX);
  assign rank_ext = wpt_pkg::HUND_W'(rank_r);

  always_comb begin
    rank_nxt   = rank_r;
    cnt_nxt    = cnt_r;
    prefix_nxt = prefix_r;
    if (ctrl.load) begin
      rank_nxt   = rank_load;
      cnt_nxt    = '0;
      prefix_nxt = '0;
    end else if (ctrl.resolve) begin
      cnt_nxt = '0;
      if (rank_ext >= hund) begin
        prefix_nxt = prefix_r | bit_sel;
        rank_nxt   = wpt_pkg::RANK_W'(rank_ext - hund);
      end
    end else if (ctrl.acc && match) begin
      cnt_nxt = cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rank_r   <= rank_nxt;
    prefix_r <= prefix_nxt;
  end

  assign prefix = prefix_r;

endmodule

>>> hw/rtl/window_percentile_tracker.sv
// ----------------------------------------------------------------------------
// window_percentile_tracker: sliding-window percentile of duration samples
// Ring of the most recent samples with an iterative bitwise rank selector.
// ----------------------------------------------------------------------------
// Usage. Requests arrive on the in_ channel (valid/ready): a push stores its
// duration, saturated to 16 bits, at the ring head; a query asks for the
// sample at the given percentile of the samples held; a clear empties the
// ring. Only a query returns a result on the out_ channel (valid/ready),
// carrying the selected sample and the number of samples held.
// A push or a clear is taken while idle and in_ready stays high. A query of n held
// samples runs sixteen passes over the store, one per result bit, each pass
// reading n entries through the single RAM read port, then going through the
// DRAIN and RESOLVE states to decide the bit; the result is registered from
// the DONE state, which an empty ring reaches directly from idle. in_ready is low
// while a query is being worked out.
// The result waits in an output register; the block goes on taking pushes
// and clears while it waits, and a later query holds its answer until the
// receiver has taken the earlier one.
// Reset empties the ring and drops any waiting result; the stored samples are
// not cleared, as only entries written since the last clear are ever read.
// ----------------------------------------------------------------------------
module window_percentile_tracker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_action,
  input  logic [wpt_pkg::DUR_W-1:0]     in_duration,
  input  logic [wpt_pkg::PCT_IN_W-1:0]  in_percent,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [wpt_pkg::SAMPLE_W-1:0]  out_percentile_value,
  output logic [wpt_pkg::CNT_W-1:0]     out_sample_count
);

  wpt_pkg::state_t               state_r, state_nxt;
  logic [wpt_pkg::ADDR_W-1:0]    head_r, head_nxt;
  logic [wpt_pkg::CNT_W-1:0]     count_r, count_nxt;
  logic [wpt_pkg::ADDR_W-1:0]    addr_r, addr_nxt;
  logic [wpt_pkg::BIT_W-1:0]     bit_r, bit_nxt;
  logic [wpt_pkg::PCT_W-1:0]     pct_r, pct_nxt;
  logic                          rd_vld_r;
  logic                          out_valid_r, out_valid_nxt;
  logic [wpt_pkg::SAMPLE_W-1:0]  out_value_r;
  logic [wpt_pkg::CNT_W-1:0]     out_count_r;

  logic                          accept;
  logic                          is_push, is_query, is_clear;
  logic                          out_free;
  logic                          scan_last;
  logic                          ram_we, ram_re;
  logic [wpt_pkg::SAMPLE_W-1:0]  sample_sat;
  logic [wpt_pkg::SAMPLE_W-1:0]  ram_rdata;
  logic [wpt_pkg::CNT_W-1:0]     count_m1;
  logic [wpt_pkg::PCT_W+wpt_pkg::CNT_W-1:0] rank_prod;
  logic [wpt_pkg::RANK_W-1:0]    rank_load;
  logic [wpt_pkg::SAMPLE_W-1:0]  prefix;
  wpt_pkg::rank_ctrl_t           rank_ctrl;

  assign accept   = in_valid && in_ready;
  assign is_push  = (in_action == wpt_pkg::ACT_PUSH);
  assign is_query = (in_action == wpt_pkg::ACT_QUERY);
  assign is_clear = (in_action == wpt_pkg::ACT_CLEAR);
  assign out_free = !out_valid_r || out_ready;

  // Durations that do not fit in 16 bits store as all ones.
  assign sample_sat = (in_duration[wpt_pkg::DUR_W-1:wpt_pkg::SAMPLE_W] != '0)
                      ? {wpt_pkg::SAMPLE_W{1'b1}} : in_duration[wpt_pkg::SAMPLE_W-1:0];

  // After a clear the head restarts at zero, so the held samples always sit
  // in entries 0 to count-1 and a pass simply walks that range.
  assign count_m1  = count_r - 1'b1;
  assign scan_last = (wpt_pkg::CNT_W'(addr_r) == count_m1);

  // The rank is kept scaled by one hundred, which removes the division.
  assign rank_prod = pct_r * count_m1;
  assign rank_load = (state_r == wpt_pkg::ST_SETUP) ? wpt_pkg::RANK_W'(rank_prod) : '0;

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      wpt_pkg::ST_IDLE: begin
        if (accept && is_query) begin
          state_nxt = (count_r == '0) ? wpt_pkg::ST_DONE : wpt_pkg::ST_SETUP;
        end
      end
      wpt_pkg::ST_SETUP: begin
        state_nxt = wpt_pkg::ST_SCAN;
      end
      wpt_pkg::ST_SCAN: begin
        if (scan_last) begin
          state_nxt = wpt_pkg::ST_DRAIN;
        end
      end
      wpt_pkg::ST_DRAIN: begin
        state_nxt = wpt_pkg::ST_RESOLVE;
      end
      wpt_pkg::ST_RESOLVE: begin
        state_nxt = (bit_r == '0) ? wpt_pkg::ST_DONE : wpt_pkg::ST_SCAN;
      end
      wpt_pkg::ST_DONE: begin
        if (out_free) begin
          state_nxt = wpt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = wpt_pkg::ST_IDLE;
      end
    endcase
  end

  // Output and datapath control.
  always_comb begin
    in_ready          = 1'b0;
    ram_we            = 1'b0;
    ram_re            = 1'b0;
    rank_ctrl.load    = 1'b0;
    rank_ctrl.acc     = rd_vld_r;
    rank_ctrl.resolve = 1'b0;
    head_nxt          = head_r;
    count_nxt         = count_r;
    addr_nxt          = addr_r;
    bit_nxt           = bit_r;
    pct_nxt           = pct_r;
    out_valid_nxt     = out_valid_r && !out_ready;
    case (state_r)
      wpt_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (accept) begin
          if (is_push) begin
            ram_we   = 1'b1;
            head_nxt = (head_r == wpt_pkg::ADDR_W'(wpt_pkg::WINDOW - 1))
                       ? '0 : head_r + 1'b1;
            if (count_r != wpt_pkg::CNT_W'(wpt_pkg::WINDOW)) begin
              count_nxt = count_r + 1'b1;
            end
          end else if (is_query) begin
            // Clears the prefix, so an empty ring answers zero.
            rank_ctrl.load = 1'b1;
            pct_nxt = (in_percent > wpt_pkg::PCT_IN_W'(wpt_pkg::PCT_MAX))
                      ? wpt_pkg::PCT_W'(wpt_pkg::PCT_MAX) : in_percent[wpt_pkg::PCT_W-1:0];
          end else if (is_clear) begin
            head_nxt  = '0;
            count_nxt = '0;
          end
        end
      end
      wpt_pkg::ST_SETUP: begin
        rank_ctrl.load = 1'b1;
        addr_nxt       = '0;
        bit_nxt        = wpt_pkg::BIT_W'(wpt_pkg::SAMPLE_W - 1);
      end
      wpt_pkg::ST_SCAN: begin
        ram_re   = 1'b1;
        addr_nxt = addr_r + 1'b1;
      end
      wpt_pkg::ST_RESOLVE: begin
        rank_ctrl.resolve = 1'b1;
        addr_nxt          = '0;
        bit_nxt           = bit_r - 1'b1;
      end
      wpt_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= wpt_pkg::ST_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      rd_vld_r    <= ram_re;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r <= addr_nxt;
    bit_r  <= bit_nxt;
    pct_r  <= pct_nxt;
    if (state_r == wpt_pkg::ST_DONE && out_free) begin
      out_value_r <= prefix;
      out_count_r <= count_r;
    end
  end

  wpt_sample_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (head_r),
    .wdata (sample_sat),
    .re    (ram_re),
    .raddr (addr_r),
    .rdata (ram_rdata)
  );

  wpt_rank_unit u_rank (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (rank_ctrl),
    .rank_load (rank_load),
    .bit_idx   (bit_r),
    .sample    (ram_rdata),
    .prefix    (prefix)
  );

  assign out_valid            = out_valid_r;
  assign out_percentile_value = out_value_r;
  assign out_sample_count     = out_count_r;

endmodule
